/* src/gmpc_pkg.sv */
// shared types and constants for the grid minimum path cost core
// used by gmpc_ctrl, gmpc_datapath and grid_min_path_cost_dp_core; no dependencies
package gmpc_pkg;

    localparam int DEF_MAX_ROWS   = 8;
    localparam int DEF_MAX_COLS   = 8;
    localparam int DEF_COST_BITS  = 16;

    localparam int CELL_COST_BITS = 16;
    localparam int BEST_BITS      = 22;
    localparam int RC_BITS        = 3;
    localparam int DIM_BITS       = 4;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // store the accepted cell cost
        logic back_init;  // point counters at the bottom-right cell
        logic back_rd;    // read own cost and lower neighbor
        logic back_wr;    // compute and write cost-to-end, step back
        logic emit_init;  // point counters at the top-left cell
        logic emit_rd;    // read stored result entry
        logic emit_ld;    // load output register, step forward
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_last;
        logic back_last;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* src/gmpc_ctrl.sv */
// controller state machine: load, backward pass, emit
// depends on gmpc_pkg for the command and status structs
module gmpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cell_valid,
    output logic              o_cell_stall,
    input  gmpc_pkg::t_dp_sts i_sts,
    output gmpc_pkg::t_dp_cmd o_cmd
);
    import gmpc_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_BRD   = 5'b00010,
        S_BCALC = 5'b00100,
        S_ERD   = 5'b01000,
        S_ELD   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_cell_stall = (r_state != S_LOAD);
    assign accept       = i_cell_valid && (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                o_cmd.load = accept;
                if (accept && i_sts.load_last) begin
                    o_cmd.back_init = 1'b1;
                    n_state         = S_BRD;
                end
            end
            S_BRD: begin
                o_cmd.back_rd = 1'b1;
                n_state       = S_BCALC;
            end
            S_BCALC: begin
                o_cmd.back_wr = 1'b1;
                if (i_sts.back_last) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_ERD;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_ERD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_ELD;
            end
            S_ELD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    n_state       = i_sts.emit_last ? S_LOAD : S_ERD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/gmpc_datapath.sv */
// datapath: grid dimensions, cost and result memories, counters, output register
// depends on gmpc_pkg for widths, register indexes and the command/status structs
module gmpc_datapath #(
    parameter int MAX_ROWS  = gmpc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gmpc_pkg::DEF_MAX_COLS,
    parameter int COST_BITS = gmpc_pkg::DEF_COST_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gmpc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [gmpc_pkg::DIM_BITS-1:0]       i_cfg_data,
    input  logic [gmpc_pkg::CELL_COST_BITS-1:0] i_cell_cost,
    input  gmpc_pkg::t_dp_cmd                   i_cmd,
    output gmpc_pkg::t_dp_sts                   o_sts,
    input  logic                                i_res_stall,
    output logic                                o_res_valid,
    output logic [gmpc_pkg::RC_BITS-1:0]        o_cell_row,
    output logic [gmpc_pkg::RC_BITS-1:0]        o_cell_col,
    output logic [gmpc_pkg::BEST_BITS-1:0]      o_cost_to_end,
    output logic                                o_go_down,
    output logic                                o_go_right,
    output logic                                o_last_cell
);
    import gmpc_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1) + 1;
    localparam int CW    = (COST_BITS < CELL_COST_BITS) ? COST_BITS : CELL_COST_BITS;
    localparam int EW    = BEST_BITS + 2;

    // dimensions, held already clamped into range
    logic [DIM_BITS-1:0] r_rows, r_cols, cfg_clamp_r, cfg_clamp_c;
    logic [TW-1:0]       total;
    logic [AW-1:0]       last_idx;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamp_r = DIM_BITS'(1);
        end else if (int'(i_cfg_data) > MAX_ROWS) begin
            cfg_clamp_r = DIM_BITS'(MAX_ROWS);
        end else begin
            cfg_clamp_r = i_cfg_data;
        end
        if (i_cfg_data == '0) begin
            cfg_clamp_c = DIM_BITS'(1);
        end else if (int'(i_cfg_data) > MAX_COLS) begin
            cfg_clamp_c = DIM_BITS'(MAX_COLS);
        end else begin
            cfg_clamp_c = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_BITS'(MAX_ROWS);
            r_cols <= DIM_BITS'(MAX_COLS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_COUNT: r_rows <= cfg_clamp_r;
                REG_COL_COUNT: r_cols <= cfg_clamp_c;
                default: ;
            endcase
        end
    end

    assign total    = TW'(r_rows) * TW'(r_cols);
    assign last_idx = AW'(total - TW'(1));

    // load counter
    logic [AW-1:0] r_load_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (i_cfg_we) begin
            r_load_cnt <= '0;
        end else if (i_cmd.load) begin
            r_load_cnt <= (r_load_cnt == last_idx) ? '0 : r_load_cnt + AW'(1);
        end
    end

    // walk counters shared by backward pass and emit
    logic [AW-1:0]      r_idx;
    logic [RC_BITS-1:0] r_r, r_c;
    logic [RC_BITS-1:0] last_r, last_c;
    logic               lastr, lastc;

    assign last_r = RC_BITS'(r_rows - DIM_BITS'(1));
    assign last_c = RC_BITS'(r_cols - DIM_BITS'(1));
    assign lastr  = (r_r == last_r);
    assign lastc  = (r_c == last_c);

    // emit_init comes with the final backward write and takes precedence
    always_ff @(posedge i_clk) begin
        if (i_cmd.back_init) begin
            r_idx <= last_idx;
            r_r   <= last_r;
            r_c   <= last_c;
        end else if (i_cmd.emit_init) begin
            r_idx <= '0;
            r_r   <= '0;
            r_c   <= '0;
        end else if (i_cmd.back_wr) begin
            r_idx <= r_idx - AW'(1);
            if (r_c == '0) begin
                r_c <= last_c;
                r_r <= r_r - RC_BITS'(1);
            end else begin
                r_c <= r_c - RC_BITS'(1);
            end
        end else if (i_cmd.emit_ld) begin
            r_idx <= r_idx + AW'(1);
            if (lastc) begin
                r_c <= '0;
                r_r <= r_r + RC_BITS'(1);
            end else begin
                r_c <= r_c + RC_BITS'(1);
            end
        end
    end

    // memories
    logic [CW-1:0] cost_mem [DEPTH];
    logic [EW-1:0] best_mem [DEPTH];
    logic [CW-1:0] r_cost_rd;
    logic [EW-1:0] r_best_rd;
    logic [AW-1:0] nbr_addr, best_rd_addr;
    logic          best_re;

    assign nbr_addr     = AW'(TW'(r_idx) + TW'(r_cols));
    // lower neighbor only during backward pass and off the last row
    assign best_rd_addr = (i_cmd.back_rd && !lastr) ? nbr_addr : r_idx;
    assign best_re      = i_cmd.back_rd || i_cmd.emit_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            cost_mem[r_load_cnt] <= i_cell_cost[CW-1:0];
        end
        if (i_cmd.back_rd) begin
            r_cost_rd <= cost_mem[r_idx];
        end
    end

    // backward step: own cost plus the cheaper existing lower/right neighbor
    logic [BEST_BITS-1:0] r_right_best, dn, nb_min, best_new;
    logic [BEST_BITS:0]   sum;
    logic                 flag_dn, flag_rt;

    assign dn = r_best_rd[BEST_BITS-1:0];

    always_comb begin
        nb_min  = '0;
        flag_dn = 1'b0;
        flag_rt = 1'b0;
        if (lastr && !lastc) begin
            nb_min  = r_right_best;
            flag_rt = 1'b1;
        end else if (lastc && !lastr) begin
            nb_min  = dn;
            flag_dn = 1'b1;
        end else if (!lastr && !lastc) begin
            nb_min  = (dn < r_right_best) ? dn : r_right_best;
            flag_dn = (dn <= r_right_best);
            flag_rt = (r_right_best <= dn);
        end
        sum      = {1'b0, nb_min} + (BEST_BITS + 1)'(r_cost_rd);
        // saturate at the top of the result range
        best_new = sum[BEST_BITS] ? '1 : sum[BEST_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.back_wr) begin
            best_mem[r_idx] <= {flag_dn, flag_rt, best_new};
            r_right_best    <= best_new;
        end
        if (best_re) begin
            r_best_rd <= best_mem[best_rd_addr];
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            o_cell_row    <= r_r;
            o_cell_col    <= r_c;
            o_cost_to_end <= r_best_rd[BEST_BITS-1:0];
            o_go_down     <= r_best_rd[EW-1];
            o_go_right    <= r_best_rd[EW-2];
            o_last_cell   <= (r_idx == last_idx);
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_sts.load_last = (r_load_cnt == last_idx);
    assign o_sts.back_last = (r_idx == '0);
    assign o_sts.emit_last = (r_idx == last_idx);
    assign o_sts.out_free  = !r_out_valid || !i_res_stall;

endmodule

/* src/grid_min_path_cost_dp_core.sv */
// top level of the grid minimum path cost core: controller plus datapath
// depends on gmpc_pkg, gmpc_ctrl and gmpc_datapath
//
//   channel   direction  handshake                    payload
//   cell      in         i_cell_valid / o_cell_stall  i_cell_cost
//   result    out        o_res_valid / i_res_stall    o_cell_row, o_cell_col, o_cost_to_end,
//                                                     o_go_down, o_go_right, o_last_cell
//   config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// cells load one per cycle while o_cell_stall is low; after the last of N = rows*cols cells
// the backward pass handles each cell as a single-port memory read, then a compute and write back;
// each result then leaves as a memory read followed by an output register load, and the load
// waits while the result side stalls
// synchronous active-low reset; memories need no clearing, every entry is written first
// o_cell_stall is high from the last cell until the last result is in the output register
module grid_min_path_cost_dp_core #(
    parameter int MAX_ROWS  = gmpc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gmpc_pkg::DEF_MAX_COLS,
    parameter int COST_BITS = gmpc_pkg::DEF_COST_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gmpc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [gmpc_pkg::DIM_BITS-1:0]       i_cfg_data,
    input  logic                                i_cell_valid,
    output logic                                o_cell_stall,
    input  logic [gmpc_pkg::CELL_COST_BITS-1:0] i_cell_cost,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic [gmpc_pkg::RC_BITS-1:0]        o_cell_row,
    output logic [gmpc_pkg::RC_BITS-1:0]        o_cell_col,
    output logic [gmpc_pkg::BEST_BITS-1:0]      o_cost_to_end,
    output logic                                o_go_down,
    output logic                                o_go_right,
    output logic                                o_last_cell
);
    import gmpc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    gmpc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (i_cell_valid),
        .o_cell_stall (o_cell_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    gmpc_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .COST_BITS (COST_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cell_cost   (i_cell_cost),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_res_stall   (i_res_stall),
        .o_res_valid   (o_res_valid),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_cost_to_end (o_cost_to_end),
        .o_go_down     (o_go_down),
        .o_go_right    (o_go_right),
        .o_last_cell   (o_last_cell)
    );

endmodule

/* verif/grid_min_path_cost_dp_core_tb.sv */
// self-checking testbench for grid_min_path_cost_dp_core: random and directed grids,
// a scoreboard class that recomputes the cost-to-end table, random idling on both sides
// depends on gmpc_pkg and the core rtl
module grid_min_path_cost_dp_core_tb;
    import gmpc_pkg::*;

    localparam int GRID_ROWS_MAX = DEF_MAX_ROWS;
    localparam int GRID_COLS_MAX = DEF_MAX_COLS;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [BEST_BITS:0] BEST_CEIL = 23'h3FFFFF;

    typedef struct packed {
        logic [RC_BITS-1:0]   row;
        logic [RC_BITS-1:0]   col;
        logic [BEST_BITS-1:0] cost;
        logic                 down;
        logic                 right;
        logic                 last;
    } t_path_result;

    class t_path_cost_scoreboard;
        logic [CELL_COST_BITS-1:0] cost_mem [64];
        logic [BEST_BITS-1:0]      best_mem [64];
        int unsigned               loaded;
        logic [DIM_BITS-1:0]       rows_reg;
        logic [DIM_BITS-1:0]       cols_reg;
        t_path_result              expected_q [$];
        int unsigned               errors;

        function new();
            loaded   = 0;
            rows_reg = 4'd8;
            cols_reg = 4'd8;
            errors   = 0;
        endfunction

        // 0 acts as 1, anything above the maximum acts as the maximum
        function int dim_in_use(logic [DIM_BITS-1:0] v, int maxv);
            if (v == 0) return 1;
            if (int'(v) > maxv) return maxv;
            return int'(v);
        endfunction

        function int grid_cells();
            return dim_in_use(rows_reg, GRID_ROWS_MAX) * dim_in_use(cols_reg, GRID_COLS_MAX);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] v);
            if (idx == REG_ROW_COUNT) begin
                rows_reg = v;
            end else begin
                cols_reg = v;
            end
            loaded = 0;
        endfunction

        function logic [BEST_BITS-1:0] sat_sum(logic [BEST_BITS-1:0] a, logic [BEST_BITS-1:0] b);
            logic [BEST_BITS:0] s;
            s = {1'b0, a} + {1'b0, b};
            return (s > BEST_CEIL) ? BEST_CEIL[BEST_BITS-1:0] : s[BEST_BITS-1:0];
        endfunction

        function void note_cell(logic [CELL_COST_BITS-1:0] cost);
            int rows;
            int cols;
            int idx;
            bit lr;
            bit lc;
            logic [BEST_BITS-1:0] own;
            logic [BEST_BITS-1:0] dn;
            logic [BEST_BITS-1:0] rt;
            t_path_result res;
            rows = dim_in_use(rows_reg, GRID_ROWS_MAX);
            cols = dim_in_use(cols_reg, GRID_COLS_MAX);
            cost_mem[loaded] = cost;
            loaded++;
            if (loaded < rows * cols) return;
            loaded = 0;
            // backward fill from the bottom-right corner
            for (int r = rows - 1; r >= 0; r--) begin
                for (int c = cols - 1; c >= 0; c--) begin
                    idx = r * cols + c;
                    lr  = (r == rows - 1);
                    lc  = (c == cols - 1);
                    own = {{(BEST_BITS-CELL_COST_BITS){1'b0}}, cost_mem[idx]};
                    if (lr && lc) begin
                        best_mem[idx] = own;
                    end else if (lr) begin
                        best_mem[idx] = sat_sum(own, best_mem[idx + 1]);
                    end else if (lc) begin
                        best_mem[idx] = sat_sum(own, best_mem[idx + cols]);
                    end else begin
                        dn = best_mem[idx + cols];
                        rt = best_mem[idx + 1];
                        best_mem[idx] = sat_sum(own, (dn < rt) ? dn : rt);
                    end
                end
            end
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    idx       = r * cols + c;
                    lr        = (r == rows - 1);
                    lc        = (c == cols - 1);
                    res.row   = r[RC_BITS-1:0];
                    res.col   = c[RC_BITS-1:0];
                    res.cost  = best_mem[idx];
                    res.down  = 1'b0;
                    res.right = 1'b0;
                    res.last  = lr && lc;
                    if (lr && !lc) begin
                        res.right = 1'b1;
                    end else if (lc && !lr) begin
                        res.down = 1'b1;
                    end else if (!lr && !lc) begin
                        dn = best_mem[idx + cols];
                        rt = best_mem[idx + 1];
                        res.down  = (dn <= rt);
                        res.right = (rt <= dn);
                    end
                    expected_q = {expected_q, res};
                end
            end
        endfunction

        function void field_check(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                $error("%s: expected %0d, actual %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_path_result got);
            t_path_result want;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: row %0d col %0d cost %0d",
                       got.row, got.col, got.cost);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            field_check("cell_row", 32'(want.row), 32'(got.row));
            field_check("cell_col", 32'(want.col), 32'(got.col));
            field_check("cost_to_end", 32'(want.cost), 32'(got.cost));
            field_check("go_down", 32'(want.down), 32'(got.down));
            field_check("go_right", 32'(want.right), 32'(got.right));
            field_check("last_cell", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index  = '0;
    logic [DIM_BITS-1:0]       cfg_data   = '0;
    logic                      cell_valid = 1'b0;
    logic                      cell_stall;
    logic [CELL_COST_BITS-1:0] cell_cost  = '0;
    logic                      res_valid;
    logic                      res_stall  = 1'b0;
    logic [RC_BITS-1:0]        res_row;
    logic [RC_BITS-1:0]        res_col;
    logic [BEST_BITS-1:0]      res_cost;
    logic                      res_down;
    logic                      res_right;
    logic                      res_last;

    t_path_cost_scoreboard sb = new();

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int          burst_left   = 0;
    int          sink_mode    = 0;
    int          sink_seg     = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned sink_cycle   = 0;

    logic [CELL_COST_BITS-1:0] line_costs [8] =
        '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF};

    grid_min_path_cost_dp_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_cell_valid  (cell_valid),
        .o_cell_stall  (cell_stall),
        .i_cell_cost   (cell_cost),
        .o_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .o_cell_row    (res_row),
        .o_cell_col    (res_col),
        .o_cost_to_end (res_cost),
        .o_go_down     (res_down),
        .o_go_right    (res_right),
        .o_last_cell   (res_last)
    );

    always #1 clk = ~clk;

    // result side: check each accepted transaction, then choose the next stall value
    always @(posedge clk) begin
        sink_cycle++;
        if (rst_n && res_valid && !res_stall) begin
            sb.check_result(t_path_result'{row: res_row, col: res_col, cost: res_cost,
                                           down: res_down, right: res_right, last: res_last});
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else if (!hold_done && results_seen > 30 && cell_valid && cell_stall) begin
            // long hold-off while cells keep coming, so the core backs up
            hold_done = 1'b1;
            hold_left = 300;
            res_stall <= 1'b1;
        end else begin
            if (sink_seg == 0) begin
                sink_mode = $urandom_range(0, 3);
                sink_seg  = $urandom_range(20, 200);
            end
            sink_seg--;
            case (sink_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= ($urandom_range(0, 9) < 7);
                default: res_stall <= (sink_cycle % 3 == 0);
            endcase
        end
    end

    task automatic send_cell(input logic [CELL_COST_BITS-1:0] cost);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                cell_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        cell_valid <= 1'b1;
        cell_cost  <= cost;
        @(posedge clk);
        while (cell_stall) @(posedge clk);
        sb.note_cell(cost);
        items_sent++;
    endtask

    task automatic write_dim(input logic [CFG_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every expected result, then let the core settle
    task automatic wait_idle();
        cell_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CELL_COST_BITS-1:0] pick_cost(int style);
        case (style)
            0: return CELL_COST_BITS'($urandom_range(0, 3));
            1: return CELL_COST_BITS'($urandom_range(0, 65535));
            2: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return CELL_COST_BITS'($urandom_range(0, 65535));
                endcase
            end
            default: return CELL_COST_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_grid(input int style, input int count);
        for (int i = 0; i < count; i++) send_cell(pick_cost(style));
    endtask

    function automatic logic [DIM_BITS-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 16) return DIM_BITS'($urandom_range(9, 15));
        if (roll < 24) return DIM_BITS'(8);
        return DIM_BITS'($urandom_range(1, 4));
    endfunction

    initial begin
        int unsigned random_start;
        int          n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero dimensions act as a single cell
        write_dim(REG_ROW_COUNT, 4'd0);
        write_dim(REG_COL_COUNT, 4'd0);
        send_cell(16'hFFFF);
        wait_idle();

        // single row, column count above the maximum
        write_dim(REG_ROW_COUNT, 4'd1);
        write_dim(REG_COL_COUNT, 4'd15);
        for (int i = 0; i < 8; i++) send_cell(line_costs[i]);
        wait_idle();

        // single column, row count above the maximum
        write_dim(REG_ROW_COUNT, 4'd15);
        write_dim(REG_COL_COUNT, 4'd1);
        for (int i = 0; i < 8; i++) send_cell(line_costs[7 - i]);
        wait_idle();

        // equal neighbors flag both moves
        write_dim(REG_ROW_COUNT, 4'd2);
        write_dim(REG_COL_COUNT, 4'd2);
        repeat (4) send_cell(16'd5);
        wait_idle();

        // two full grids back to back
        write_dim(REG_ROW_COUNT, 4'd8);
        write_dim(REG_COL_COUNT, 4'd8);
        random_start = items_sent;
        send_grid(1, 64);
        send_grid(0, 64);
        wait_idle();

        while (items_sent - random_start < 300) begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) write_dim(REG_ROW_COUNT, pick_dim());
                else write_dim(REG_COL_COUNT, pick_dim());
            end else begin
                write_dim(REG_ROW_COUNT, pick_dim());
                write_dim(REG_COL_COUNT, pick_dim());
            end
            n = sb.grid_cells();
            repeat ($urandom_range(1, 3)) send_grid($urandom_range(0, 3), n);
            // an unfinished grid is dropped by the next register write
            if (n > 1 && $urandom_range(0, 5) == 0) send_grid(1, $urandom_range(1, n - 1));
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/gmpc_pkg.sv
src/gmpc_ctrl.sv
src/gmpc_datapath.sv
src/grid_min_path_cost_dp_core.sv
verif/grid_min_path_cost_dp_core_tb.sv
